FILE: hdl/psd_pkg.sv
// Shared types and constants of the per-bin spectral delay.
package psd_pkg;

  localparam int BIN_W        = 13;
  localparam int CURVE_W      = 16;
  localparam int SAMPLE_W     = 24;
  localparam int REG_W        = 18;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_TDATA_W   = 128;
  localparam int OUT_TDATA_W  = 112;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_OFFSET = 2'd1;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right_imag;
    logic [SAMPLE_W-1:0] right_real;
    logic [SAMPLE_W-1:0] left_imag;
    logic [SAMPLE_W-1:0] left_real;
  } bin_vals_t;

  typedef struct packed {
    logic             cmd;
    logic [BIN_W-1:0] bin;
    logic [CURVE_W-1:0] curve;
    bin_vals_t        vals;
  } item_t;

endpackage

FILE: hdl/psd_bin_state.sv
// Per-bin state memory (curve value, fill count, ring pointer) with clearing sweep.
module psd_bin_state #(
  parameter int MAX_BINS = 1025,
  parameter int ENTRY_W  = 37
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_BINS)-1:0] rd_addr,
  output logic [ENTRY_W-1:0]          rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_BINS)-1:0] wr_addr,
  input  logic [ENTRY_W-1:0]          wr_data,
  output logic                        clearing
);
  import psd_pkg::*;

  localparam int AW = $clog2(MAX_BINS);

  logic [ENTRY_W-1:0] mem [MAX_BINS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               clr_active_r;
  logic [AW-1:0]      clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(MAX_BINS - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Sweep zeros through every bin after reset before any request is taken.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

endmodule

FILE: hdl/psd_delay_calc.sv
// Two-stage delay computation: curve times scale, truncate, add offset, clamp.
module psd_delay_calc #(
  parameter int MAX_DELAY_FRAMES = 1024
) (
  input  logic                                clk,
  input  logic [psd_pkg::CURVE_W-1:0]         curve,
  input  logic [psd_pkg::REG_W-1:0]           scale,
  input  logic [psd_pkg::REG_W-1:0]           offset,
  output logic [$clog2(MAX_DELAY_FRAMES)-1:0] delay
);
  import psd_pkg::*;

  localparam int FRAME_W = $clog2(MAX_DELAY_FRAMES);
  localparam int PROD_W  = CURVE_W + REG_W + 1;
  localparam int Q_W     = PROD_W - 15;
  localparam int SUM_W   = REG_W + 3;
  localparam logic signed [SUM_W-1:0] D_MAX = SUM_W'(MAX_DELAY_FRAMES - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] biased;
  logic signed [Q_W-1:0]    quot;
  logic signed [SUM_W-1:0]  sum;
  logic [FRAME_W-1:0]       delay_nxt;
  logic [FRAME_W-1:0]       delay_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed({{(PROD_W - CURVE_W){curve[CURVE_W-1]}}, curve})
            * $signed({{(PROD_W - REG_W){1'b0}}, scale});
  end

  // Bias negative products so the shift truncates toward zero.
  always_comb begin
    biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    quot   = biased[PROD_W-1:15];
    sum    = SUM_W'(quot) + $signed({3'b000, offset});
    if (sum < 0) begin
      delay_nxt = '0;
    end else if (sum > D_MAX) begin
      delay_nxt = FRAME_W'(MAX_DELAY_FRAMES - 1);
    end else begin
      delay_nxt = sum[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    delay_r <= delay_nxt;
  end

  assign delay = delay_r;

endmodule

FILE: hdl/psd_ring_store.sv
// Delay-line store: one ring of frames per bin, one write and one read port.
module psd_ring_store #(
  parameter int DEPTH  = 1049600,
  parameter int DATA_W = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);
  import psd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/per_bin_spectral_delay_top.sv
// Per-bin spectral delay: sequencer, configuration registers and output register.
// Usage:
//   Input channel in_*: one request per bin. tuser is cmd (0 process, 1 load
//   curve value). A load writes the bin's Q1.15 curve value and returns nothing;
//   a process request returns one result on out_* with the bin's values delayed
//   by its own frame count. Bins at or above MAX_BINS are dropped.
//   Configuration channel cfg_*: index 0 delay_scale, 1 global_offset_frames;
//   always ready, other indexes are ignored. Write only while the block is idle.
// Sequence:
//   A process request passes through bin-state read, multiply, delay clamp,
//   ring read-modify-write and output load, in that order; the output load
//   waits while the output register is full. A load request does a bin-state
//   read, then a write back; a dropped bin leaves the sequencer idle. One
//   request is in flight at a time: in_tready is low until the sequencer is idle.
// Reset:
//   rst_n clears the sequencer, output valid and configuration registers, then a
//   sweep zeroes every bin-state entry; in_tready stays low during the sweep.
// Stall:
//   The finished result holds in the output register while out_tready is low;
//   the next request is then worked up to the output stage and waits there.
module per_bin_spectral_delay_top #(
  parameter int MAX_BINS         = 1025,
  parameter int MAX_DELAY_FRAMES = 1024,
  parameter int SAMPLE_BITS      = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // bin[12:0], curve_value[28:13], left_real[52:29], left_imag[76:53],
  // right_real[100:77], right_imag[124:101], zero[127:125]
  input  logic [psd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // cmd[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_bin[12:0], delayed_left_real[36:13], delayed_left_imag[60:37],
  // delayed_right_real[84:61], delayed_right_imag[108:85], zero[111:109]
  output logic [psd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psd_pkg::REG_W-1:0]            cfg_data
);
  import psd_pkg::*;

  localparam int BIN_IW   = $clog2(MAX_BINS);
  localparam int FRAME_W  = $clog2(MAX_DELAY_FRAMES);
  localparam int FILL_W   = $clog2(MAX_DELAY_FRAMES + 1);
  localparam int ENTRY_W  = CURVE_W + FILL_W + FRAME_W;
  localparam int DEPTH    = MAX_BINS * MAX_DELAY_FRAMES;
  localparam int SA_W     = $clog2(DEPTH);
  localparam int KEEP_W   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int DATA_W   = 4 * KEEP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DLY,
    ST_UPD,
    ST_OUT,
    ST_LOAD
  } state_t;

  state_t                  st_r;
  item_t                   item_in;
  item_t                   item_r;
  logic [REG_W-1:0]        scale_r;
  logic [REG_W-1:0]        offset_r;
  logic                    in_accept;
  logic                    in_range;
  logic                    clearing;

  logic [ENTRY_W-1:0]      entry;
  logic [CURVE_W-1:0]      entry_curve;
  logic [FILL_W-1:0]       entry_fill;
  logic [FRAME_W-1:0]      entry_ptr;
  logic                    bs_wr_en;
  logic [ENTRY_W-1:0]      bs_wr_data;

  logic [FRAME_W-1:0]      delay;
  logic [SA_W-1:0]         base_r;
  logic [FILL_W:0]         fill_inc;
  logic [FILL_W:0]         fill_cap;
  logic [FILL_W:0]         fill_min;
  logic [FILL_W-1:0]       fill_new;
  logic [FRAME_W-1:0]      ptr_new;
  logic [FRAME_W:0]        rp_wide;
  logic [FRAME_W-1:0]      rp;
  logic [SA_W-1:0]         wr_addr;
  logic [SA_W-1:0]         rd_addr;
  logic                    sel_cur_nxt;
  logic                    sel_cur_r;

  logic [DATA_W-1:0]       cur_keep;
  logic [DATA_W-1:0]       store_rd;
  logic [DATA_W-1:0]       res_keep;
  logic                    ring_wr_en;
  logic                    out_load;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [OUT_TDATA_W-1:0]  out_data_nxt;

  always_comb begin
    item_in.cmd             = in_tuser;
    item_in.bin             = in_tdata[BIN_W-1:0];
    item_in.curve           = in_tdata[BIN_W +: CURVE_W];
    item_in.vals.left_real  = in_tdata[BIN_W + CURVE_W +: SAMPLE_W];
    item_in.vals.left_imag  = in_tdata[BIN_W + CURVE_W + SAMPLE_W +: SAMPLE_W];
    item_in.vals.right_real = in_tdata[BIN_W + CURVE_W + 2*SAMPLE_W +: SAMPLE_W];
    item_in.vals.right_imag = in_tdata[BIN_W + CURVE_W + 3*SAMPLE_W +: SAMPLE_W];
  end

  assign in_tready = (st_r == ST_IDLE) && !clearing;
  assign in_accept = in_tvalid && in_tready;
  assign in_range  = item_in.bin < BIN_W'(MAX_BINS);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= '0;
      offset_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DELAY_SCALE:   scale_r  <= cfg_data;
        REG_GLOBAL_OFFSET: offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bin-state entry layout: {curve, fill, pointer}.
  assign entry_curve = entry[ENTRY_W-1 -: CURVE_W];
  assign entry_fill  = entry[FRAME_W +: FILL_W];
  assign entry_ptr   = entry[FRAME_W-1:0];

  psd_bin_state #(
    .MAX_BINS (MAX_BINS),
    .ENTRY_W  (ENTRY_W)
  ) u_bin_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept && in_range),
    .rd_addr  (item_in.bin[BIN_IW-1:0]),
    .rd_data  (entry),
    .wr_en    (bs_wr_en),
    .wr_addr  (item_r.bin[BIN_IW-1:0]),
    .wr_data  (bs_wr_data),
    .clearing (clearing)
  );

  psd_delay_calc #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES)
  ) u_delay_calc (
    .clk    (clk),
    .curve  (entry_curve),
    .scale  (scale_r),
    .offset (offset_r),
    .delay  (delay)
  );

  // Ring update: push at the pointer, cap the fill, read delay frames back.
  always_comb begin
    fill_inc    = {1'b0, entry_fill} + 1'b1;
    fill_cap    = (FILL_W + 1)'(delay) + 1'b1;
    fill_min    = (fill_inc > fill_cap) ? fill_cap : fill_inc;
    fill_new    = fill_min[FILL_W-1:0];
    ptr_new     = (entry_ptr == FRAME_W'(MAX_DELAY_FRAMES - 1)) ? '0 : entry_ptr + 1'b1;
    if (entry_ptr >= delay) begin
      rp_wide = {1'b0, entry_ptr} - {1'b0, delay};
    end else begin
      rp_wide = {1'b0, entry_ptr} + (FRAME_W + 1)'(MAX_DELAY_FRAMES) - {1'b0, delay};
    end
    rp          = rp_wide[FRAME_W-1:0];
    wr_addr     = base_r + SA_W'(entry_ptr);
    rd_addr     = base_r + SA_W'(rp);
    // A zero delay reads the entry being written; take the current values.
    sel_cur_nxt = !(fill_min > (FILL_W + 1)'(delay)) || (delay == '0);
  end

  always_comb begin
    bs_wr_en   = (st_r == ST_UPD) || (st_r == ST_LOAD);
    bs_wr_data = (st_r == ST_LOAD) ? {item_r.curve, entry_fill, entry_ptr}
                                   : {entry_curve, fill_new, ptr_new};
  end

  assign cur_keep = {item_r.vals.right_imag[KEEP_W-1:0], item_r.vals.right_real[KEEP_W-1:0],
                     item_r.vals.left_imag[KEEP_W-1:0],  item_r.vals.left_real[KEEP_W-1:0]};
  assign ring_wr_en = (st_r == ST_UPD);

  psd_ring_store #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ring_store (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (wr_addr),
    .wr_data (cur_keep),
    .rd_en   (ring_wr_en),
    .rd_addr (rd_addr),
    .rd_data (store_rd)
  );

  always_comb begin
    res_keep     = sel_cur_r ? cur_keep : store_rd;
    out_data_nxt = '0;
    out_data_nxt[BIN_W-1:0]                   = item_r.bin;
    out_data_nxt[BIN_W +: SAMPLE_W]           = SAMPLE_W'(res_keep[0 +: KEEP_W]);
    out_data_nxt[BIN_W + SAMPLE_W +: SAMPLE_W]   = SAMPLE_W'(res_keep[KEEP_W +: KEEP_W]);
    out_data_nxt[BIN_W + 2*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(res_keep[2*KEEP_W +: KEEP_W]);
    out_data_nxt[BIN_W + 3*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(res_keep[3*KEEP_W +: KEEP_W]);
  end

  // Load when the output register is free or drains this cycle; else hold it.
  assign out_load      = (st_r == ST_OUT) && (!out_valid_r || out_tready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (in_accept && in_range) begin
            item_r <= item_in;
            st_r   <= (item_in.cmd == CMD_LOAD) ? ST_LOAD : ST_MUL;
          end
        end
        ST_MUL: begin
          base_r <= SA_W'(item_r.bin[BIN_IW-1:0]) * SA_W'(MAX_DELAY_FRAMES);
          st_r   <= ST_DLY;
        end
        ST_DLY: begin
          st_r <= ST_UPD;
        end
        ST_UPD: begin
          sel_cur_r <= sel_cur_nxt;
          st_r      <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free or drains this cycle.
          if (out_load) begin
            out_data_r <= out_data_nxt;
            st_r       <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          st_r <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sim/per_bin_spectral_delay_top_tb.sv
// Self-checking testbench of the per-bin spectral delay: predicts each bin's delayed values.
`timescale 1ns / 100ps

class delay_line_scoreboard;
  localparam int BINS     = 1025;
  localparam int RING_LEN = 1024;

  typedef struct packed {
    psd_pkg::bin_vals_t vals;
    logic [12:0]        bin;
  } bin_result_t;

  logic [17:0]        delay_scale_q;
  logic [17:0]        offset_frames_q;
  logic [15:0]        curve_q [BINS];
  int unsigned        fill_q [BINS];
  int unsigned        wptr_q [BINS];
  psd_pkg::bin_vals_t ring_q [int unsigned];
  bin_result_t        due_results [$];
  int                 errors;

  function new();
    delay_scale_q   = '0;
    offset_frames_q = '0;
    errors          = 0;
    foreach (curve_q[i]) begin
      curve_q[i] = '0;
      fill_q[i]  = 0;
      wptr_q[i]  = 0;
    end
  endfunction

  function void write_reg(logic [psd_pkg::CFG_IDX_W-1:0] idx, logic [17:0] data);
    if (idx == psd_pkg::REG_DELAY_SCALE) begin
      delay_scale_q = data;
    end else if (idx == psd_pkg::REG_GLOBAL_OFFSET) begin
      offset_frames_q = data;
    end
  endfunction

  // Frames of delay for one bin: curve * scale / 2^15 truncated toward zero, plus offset, clamped.
  function int unsigned frames_for(int unsigned b);
    longint c;
    longint d;
    c = longint'($signed(curve_q[b]));
    d = (c * longint'(delay_scale_q)) / 32768;
    d = d + longint'(offset_frames_q);
    if (d < 0) d = 0;
    if (d > RING_LEN - 1) d = RING_LEN - 1;
    return 32'(d);
  endfunction

  function void note_request(logic cmd, logic [127:0] data);
    int unsigned        b;
    int unsigned        d;
    int unsigned        wp;
    int unsigned        fill;
    psd_pkg::bin_vals_t cur;
    bin_result_t        res;
    b = 32'(data[12:0]);
    if (b >= BINS) return;
    if (cmd == psd_pkg::CMD_LOAD) begin
      curve_q[b] = data[28:13];
      return;
    end
    cur = data[124:29];
    d   = frames_for(b);
    wp  = wptr_q[b];
    ring_q[b * RING_LEN + wp] = cur;
    wptr_q[b] = (wp + 1) % RING_LEN;
    fill = fill_q[b] + 1;
    if (fill > d + 1) fill = d + 1;
    fill_q[b] = fill;
    res.bin = data[12:0];
    if (fill > d) begin
      res.vals = ring_q[b * RING_LEN + (wp + RING_LEN - d) % RING_LEN];
    end else begin
      res.vals = cur;
    end
    due_results = {due_results, res};
  endfunction

  function void compare_field(string what, logic [23:0] want, logic [23:0] got_v);
    if (got_v !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, what, want, got_v);
    end
  endfunction

  function void check_result(logic [111:0] data);
    bin_result_t        want;
    psd_pkg::bin_vals_t got;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: result with none pending: expected nothing got %h", $time, data);
      return;
    end
    want = due_results[0];
    due_results.delete(0);
    got  = data[108:13];
    compare_field("out_bin", {11'd0, want.bin}, {11'd0, data[12:0]});
    compare_field("delayed_left_real", want.vals.left_real, got.left_real);
    compare_field("delayed_left_imag", want.vals.left_imag, got.left_imag);
    compare_field("delayed_right_real", want.vals.right_real, got.right_real);
    compare_field("delayed_right_imag", want.vals.right_imag, got.right_imag);
  endfunction
endclass

module per_bin_spectral_delay_top_tb;
  import psd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int BIN_COUNT     = 1025;
  localparam int PHASE_COUNT   = 12;
  localparam int PHASE_ITEMS   = 125;
  localparam int SCALE_MAX     = 262143;

  typedef enum int {CURVE_FULL, CURVE_SMALL, CURVE_LOWEST} curve_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [REG_W-1:0]       cfg_data;

  bit quiet = 1'b0;
  delay_line_scoreboard board;

  per_bin_spectral_delay_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** per_bin_spectral_delay_top: FAILED **");
    $finish;
  end

  // Receiver: stall in random bursts until the quiet tail of the run.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  function automatic bin_vals_t rand_vals();
    return {$urandom, $urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_curve(curve_mode_t mode);
    int v;
    unique case (mode)
      CURVE_SMALL:  v = $urandom_range(0, 8) - 4;
      CURVE_LOWEST: v = $urandom_range(0, 4) - 32768;
      default:      v = $urandom_range(0, 65535);
    endcase
    return v[15:0];
  endfunction

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_request(logic cmd, logic [BIN_W-1:0] bin, logic [CURVE_W-1:0] curve,
                              bin_vals_t vals);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tuser  = cmd;
    in_tdata  = {3'b000, vals, curve, bin};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_request(cmd, in_tdata);
    @(negedge clk);
  endtask

  // Drain pending results, then let a load still in flight settle.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_tvalid = 1'b0;
    while (board.due_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int idx);
    logic [REG_W-1:0] scale;
    logic [REG_W-1:0] offset;
    curve_mode_t      mode;
    logic [BIN_W-1:0] pool [4];
    int               sent;
    int               r;
    unique case (idx)
      7:  begin scale = REG_W'(SCALE_MAX); offset = '0;                mode = CURVE_SMALL;  end
      8:  begin scale = '0;                offset = REG_W'(SCALE_MAX); mode = CURVE_FULL;   end
      9:  begin scale = REG_W'(SCALE_MAX); offset = REG_W'(SCALE_MAX); mode = CURVE_LOWEST; end
      11: begin scale = '0;                offset = '0;                mode = CURVE_FULL;   end
      default: begin
        scale  = REG_W'($urandom_range(0, 16));
        offset = REG_W'($urandom_range(0, 12));
        mode   = CURVE_FULL;
      end
    endcase
    wait_idle();
    quiet = (idx >= PHASE_COUNT - 2);
    write_cfg(REG_DELAY_SCALE, scale);
    write_cfg(REG_GLOBAL_OFFSET, offset);
    pool[0] = idx[0] ? 13'd1024 : 13'd0;
    for (int i = 1; i < 4; i++) pool[i] = BIN_W'($urandom_range(1, BIN_COUNT - 2));
    for (int i = 0; i < 4; i++) send_request(CMD_LOAD, pool[i], pick_curve(mode), rand_vals());
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_request(CMD_PROCESS, pool[$urandom_range(0, 3)], CURVE_W'($urandom),
                     rand_vals());
        sent++;
      end else if (r < 85) begin
        send_request(CMD_LOAD, pool[$urandom_range(0, 3)], pick_curve(mode), rand_vals());
        sent++;
      end else if (r < 92) begin
        send_request(CMD_PROCESS, BIN_W'($urandom_range(0, BIN_COUNT - 1)),
                     CURVE_W'($urandom), rand_vals());
        sent++;
      end else begin
        // out-of-range bin: dropped by the block
        send_request(1'($urandom_range(0, 1)), BIN_W'($urandom_range(BIN_COUNT, 8191)),
                     CURVE_W'($urandom), rand_vals());
      end
    end
    in_tvalid = 1'b0;
  endtask

  initial begin
    board     = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_PROCESS;
    cfg_valid = 1'b0;
    cfg_index = REG_DELAY_SCALE;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    // hold off until the bin-state sweep is done
    while (!in_tready) @(posedge clk);
    @(negedge clk);

    // Directed: scale 8, offset 5 gives delays 12, 0, 1 and 5 below.
    write_cfg(REG_DELAY_SCALE, 18'd8);
    write_cfg(REG_GLOBAL_OFFSET, 18'd5);
    write_cfg(REG_SPARE_2, 18'h3FFFF);
    write_cfg(REG_SPARE_3, REG_W'($urandom));
    send_request(CMD_LOAD, 13'd0, 16'h7FFF, rand_vals());
    send_request(CMD_LOAD, 13'd1024, 16'h8000, rand_vals());
    // -16385 * 8 / 32768 truncates to -4, not -5
    send_request(CMD_LOAD, 13'd3, 16'hBFFF, rand_vals());
    send_request(CMD_LOAD, 13'd1025, 16'h7FFF, rand_vals());
    send_request(CMD_LOAD, 13'd8191, 16'h0000, rand_vals());
    send_request(CMD_PROCESS, 13'd1024, 16'h0000,
                 {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    send_request(CMD_PROCESS, 13'd1024, 16'hFFFF,
                 {24'h800000, 24'h800000, 24'h800000, 24'h800000});
    send_request(CMD_PROCESS, 13'd3, 16'h0000, '0);
    send_request(CMD_PROCESS, 13'd3, 16'hFFFF, '1);
    send_request(CMD_PROCESS, 13'd3, 16'h8000,
                 {24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF});
    send_request(CMD_PROCESS, 13'd0, CURVE_W'($urandom), rand_vals());
    send_request(CMD_PROCESS, 13'd0, CURVE_W'($urandom), rand_vals());
    send_request(CMD_PROCESS, 13'd8191, CURVE_W'($urandom), rand_vals());
    send_request(CMD_PROCESS, 13'd1025, CURVE_W'($urandom), rand_vals());
    send_request(CMD_PROCESS, 13'd5, CURVE_W'($urandom), rand_vals());
    send_request(CMD_PROCESS, 13'd5, CURVE_W'($urandom), rand_vals());
    send_request(CMD_PROCESS, 13'd1024, CURVE_W'($urandom), rand_vals());

    for (int p = 0; p < PHASE_COUNT; p++) run_phase(p);

    wait_idle();
    if (board.due_results.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived, first expected %h", $time,
               board.due_results.size(), board.due_results[0]);
    end
    if (board.errors == 0) begin
      $display("** per_bin_spectral_delay_top: PASSED **");
    end else begin
      $display("** per_bin_spectral_delay_top: FAILED **");
    end
    $finish;
  end
endmodule
